### src/cba_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_pkg
// Shared types and constants of the caching block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

    localparam int IDLE_ENTRIES = 32;
    localparam int LIVE_ENTRIES = 64;

    localparam int SIZE_W  = 41;
    localparam int ADDR_W  = 48;
    localparam int STAMP_W = 16;

    localparam int IDLE_AW  = (IDLE_ENTRIES > 1) ? $clog2(IDLE_ENTRIES) : 1;
    localparam int LIVE_AW  = (LIVE_ENTRIES > 1) ? $clog2(LIVE_ENTRIES) : 1;
    localparam int SCAN_MAX = (IDLE_ENTRIES > LIVE_ENTRIES) ? IDLE_ENTRIES : LIVE_ENTRIES;
    localparam int SCAN_CW  = $clog2(SCAN_MAX + 1);
    localparam int REN_CW   = $clog2(IDLE_ENTRIES + 1);

    localparam logic [ADDR_W-1:0]  BUDGET_RESET = 48'd1073741824;
    localparam logic [SIZE_W-1:0]  REQ_CAP      = 41'h100_0000_0000;
    localparam logic [SIZE_W-1:0]  SMALL_LIMIT  = 41'd524288;
    localparam logic [SIZE_W-1:0]  MIN_BLOCK    = 41'd256;
    localparam logic [SIZE_W-1:0]  LARGE_STEP   = 41'd1048576;
    localparam logic [STAMP_W-1:0] STAMP_LIMIT  = 16'hFFFF;

    typedef enum logic [2:0] {
        RES_HIT      = 3'd0,
        RES_GRANT    = 3'd1,
        RES_RELEASED = 3'd2,
        RES_FAIL     = 3'd3,
        RES_BAD_FREE = 3'd4,
        RES_FULL     = 3'd5,
        RES_NULL     = 3'd6
    } cba_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALLOC_SCAN,
        ST_ALLOC_DECIDE,
        ST_TRIM_SCAN,
        ST_TRIM_REL,
        ST_FREE_SCAN,
        ST_FREE_DECIDE,
        ST_REN_SCAN,
        ST_REN_WRITE,
        ST_FREE_STORE,
        ST_EMIT
    } cba_state_t;

    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [ADDR_W-1:0]  addr;
        logic [STAMP_W-1:0] stamp;
    } cba_idle_t;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [SIZE_W-1:0] size;
    } cba_live_t;

endpackage : cba_pkg
`default_nettype wire

### src/cba_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cba_round
// Rounds a requested byte count to the block size the cache hands out.
// ----------------------------------------------------------------------------
module cba_round
    import cba_pkg::*;
(
    input  wire logic [SIZE_W-1:0] req_bytes,
    output logic      [SIZE_W-1:0] need_bytes
);

    logic [SIZE_W-1:0] capped;
    logic [19:0]       smear;
    logic [19:0]       pow2;
    logic [SIZE_W:0]   large_sum;

    always_comb
    begin
        // clamp oversized requests
        capped = (req_bytes > REQ_CAP) ? REQ_CAP : req_bytes;
        // next power of two by smearing the bits of n-1
        smear = capped[19:0] - 20'd1;
        smear = smear | (smear >> 1);
        smear = smear | (smear >> 2);
        smear = smear | (smear >> 4);
        smear = smear | (smear >> 8);
        smear = smear | (smear >> 16);
        pow2  = smear + 20'd1;
        // large requests round up to whole megabytes
        large_sum = {1'b0, capped} + {1'b0, LARGE_STEP - 41'd1};
        large_sum = large_sum & ~{1'b0, LARGE_STEP - 41'd1};
        if (capped <= SMALL_LIMIT)
        begin
            need_bytes = ({21'd0, pow2} < MIN_BLOCK) ? MIN_BLOCK : {21'd0, pow2};
        end
        else
        begin
            need_bytes = large_sum[SIZE_W-1:0];
        end
    end

endmodule : cba_round
`default_nettype wire

### src/caching_block_allocator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// caching_block_allocator_core
// Best-fit block cache in front of a backend allocator.
// ----------------------------------------------------------------------------
// One request at a time. Idle and live block tables sit in synchronous
// memories with one write and one read port, scanned one entry per cycle.
// A non-null allocate with a free live slot scans the idle table, plus one
// more idle scan per released block when the budget is exceeded; a free of
// a nonzero address scans the live table. When the free stamp counter wraps,
// a renumbering pass of n+1 idle-table scans runs, n being the number of idle
// blocks. Each result waits in an output register; the next request is taken while the last result is unread.
module caching_block_allocator_core
    import cba_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // budget register
    input  wire logic        cfg_wr_en,
    input  wire logic [47:0] cfg_wr_data,
    // request stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,    // req_bytes[40:0], block_address[88:41]
    input  wire logic        s_tuser,    // kind
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [95:0] m_tdata,    // address[47:0], size_bytes[88:48]
    output logic      [2:0]  m_tuser,    // status
    output logic             m_tlast
);

    // memories
    cba_idle_t idle_mem [IDLE_ENTRIES];
    cba_live_t live_mem [LIVE_ENTRIES];
    cba_idle_t idle_rdata_reg;
    cba_live_t live_rdata_reg;

    logic               idle_we, live_we;
    logic [IDLE_AW-1:0] idle_waddr;
    logic [LIVE_AW-1:0] live_waddr;
    cba_idle_t          idle_wdata;
    cba_live_t          live_wdata;

    // control state
    cba_state_t state_reg, state_next, after_reg, after_next;
    logic [ADDR_W-1:0]       max_reg, owned_reg, owned_next;
    logic [STAMP_W-1:0]      cnt_reg, cnt_next;
    logic [IDLE_ENTRIES-1:0] idle_vld_reg, idle_vld_next;
    logic [LIVE_ENTRIES-1:0] live_vld_reg, live_vld_next;
    logic [IDLE_ENTRIES-1:0] done_reg, done_next;
    logic [REN_CW-1:0]       ren_k_reg, ren_k_next;
    logic [SCAN_CW-1:0]      sidx_reg, sidx_next, didx_reg, didx_next;
    logic                    dv_reg, dv_next;
    logic                    found_reg, found_next;

    // payload registers
    logic [SIZE_W-1:0]  need_reg, need_next, fsize_reg, fsize_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [LIVE_AW-1:0] slot_reg, slot_next;
    logic [SCAN_CW-1:0] best_idx_reg, best_idx_next;
    logic [SIZE_W-1:0]  best_size_reg, best_size_next;
    logic [ADDR_W-1:0]  best_addr_reg, best_addr_next;
    logic [STAMP_W-1:0] best_stamp_reg, best_stamp_next;
    cba_status_t        res_status_reg, res_status_next, o_status_reg, o_status_next;
    logic [ADDR_W-1:0]  res_addr_reg, res_addr_next, o_addr_reg, o_addr_next;
    logic [SIZE_W-1:0]  res_size_reg, res_size_next, o_size_reg, o_size_next;
    logic               res_last_reg, res_last_next, o_last_reg, o_last_next;
    logic               ov_reg, ov_next;

    // combinational helpers
    logic [SIZE_W-1:0]       round_need;
    logic [LIVE_AW-1:0]      live_free_idx;
    logic [IDLE_AW-1:0]      idle_free_idx;
    logic                    live_full, idle_full;
    logic [SCAN_CW-1:0]      lim;
    logic                    scan_done, cand, better;
    logic [SIZE_W-1:0]       r_size;
    logic [ADDR_W-1:0]       r_addr;
    logic [STAMP_W-1:0]      r_stamp;
    logic [ADDR_W-1:0]       owned_add, owned_drop;
    logic [IDLE_ENTRIES-1:0] clr_mask;
    logic                    out_free;

    cba_round u_round
    (
        .req_bytes  (s_tdata[40:0]),
        .need_bytes (round_need)
    );

    // first free entries of both tables
    always_comb
    begin
        live_free_idx = '0;
        for (int i = LIVE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!live_vld_reg[i])
            begin
                live_free_idx = LIVE_AW'(i);
            end
        end
        idle_free_idx = '0;
        for (int i = IDLE_ENTRIES - 1; i >= 0; i--)
        begin
            if (!idle_vld_reg[i])
            begin
                idle_free_idx = IDLE_AW'(i);
            end
        end
        live_full = &live_vld_reg;
        idle_full = &idle_vld_reg;
    end

    assign out_free = !ov_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // memory read and write ports
    always_ff @(posedge clk)
    begin
        if (idle_we)
        begin
            idle_mem[idle_waddr] <= idle_wdata;
        end
        idle_rdata_reg <= idle_mem[sidx_reg[IDLE_AW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (live_we)
        begin
            live_mem[live_waddr] <= live_wdata;
        end
        live_rdata_reg <= live_mem[sidx_reg[LIVE_AW-1:0]];
    end

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        after_next      = after_reg;
        owned_next      = owned_reg;
        cnt_next        = cnt_reg;
        idle_vld_next   = idle_vld_reg;
        live_vld_next   = live_vld_reg;
        done_next       = done_reg;
        ren_k_next      = ren_k_reg;
        sidx_next       = sidx_reg;
        didx_next       = didx_reg;
        dv_next         = 1'b0;
        found_next      = found_reg;
        need_next       = need_reg;
        fsize_next      = fsize_reg;
        addr_next       = addr_reg;
        slot_next       = slot_reg;
        best_idx_next   = best_idx_reg;
        best_size_next  = best_size_reg;
        best_addr_next  = best_addr_reg;
        best_stamp_next = best_stamp_reg;
        res_status_next = res_status_reg;
        res_addr_next   = res_addr_reg;
        res_size_next   = res_size_reg;
        res_last_next   = res_last_reg;
        o_status_next   = o_status_reg;
        o_addr_next     = o_addr_reg;
        o_size_next     = o_size_reg;
        o_last_next     = o_last_reg;
        ov_next         = m_tready ? 1'b0 : ov_reg;
        idle_we         = 1'b0;
        idle_waddr      = idle_free_idx;
        idle_wdata      = '{size: fsize_reg, addr: addr_reg, stamp: cnt_reg};
        live_we         = 1'b0;
        live_waddr      = slot_reg;
        live_wdata      = '{addr: addr_reg, size: need_reg};

        // scan bookkeeping
        lim = (state_reg == ST_FREE_SCAN) ? SCAN_CW'(LIVE_ENTRIES) : SCAN_CW'(IDLE_ENTRIES);
        if (sidx_reg < lim)
        begin
            sidx_next = sidx_reg + SCAN_CW'(1);
            dv_next   = 1'b1;
            didx_next = sidx_reg;
        end
        scan_done = (sidx_reg == lim) && !dv_reg;

        if (state_reg == ST_FREE_SCAN)
        begin
            r_size  = live_rdata_reg.size;
            r_addr  = live_rdata_reg.addr;
            r_stamp = '0;
        end
        else
        begin
            r_size  = idle_rdata_reg.size;
            r_addr  = idle_rdata_reg.addr;
            r_stamp = idle_rdata_reg.stamp;
        end

        // candidate test for the current scan
        cand   = 1'b0;
        better = 1'b0;
        priority case (state_reg)
            ST_ALLOC_SCAN:
            begin
                cand   = idle_vld_reg[didx_reg[IDLE_AW-1:0]] && (r_size >= need_reg);
                better = !found_reg || (r_size < best_size_reg) ||
                         ((r_size == best_size_reg) && (r_stamp < best_stamp_reg));
            end
            ST_TRIM_SCAN:
            begin
                cand   = idle_vld_reg[didx_reg[IDLE_AW-1:0]];
                better = !found_reg || (r_size > best_size_reg) ||
                         ((r_size == best_size_reg) && (r_stamp > best_stamp_reg));
            end
            ST_REN_SCAN:
            begin
                cand   = idle_vld_reg[didx_reg[IDLE_AW-1:0]] &&
                         !done_reg[didx_reg[IDLE_AW-1:0]];
                better = !found_reg || (r_stamp < best_stamp_reg);
            end
            ST_FREE_SCAN:
            begin
                cand   = live_vld_reg[didx_reg[LIVE_AW-1:0]] && (r_addr == addr_reg);
                better = !found_reg;
            end
            default:
            begin
                cand   = 1'b0;
                better = 1'b0;
            end
        endcase
        if (dv_reg && cand && better)
        begin
            found_next      = 1'b1;
            best_idx_next   = didx_reg;
            best_size_next  = r_size;
            best_addr_next  = r_addr;
            best_stamp_next = r_stamp;
        end

        owned_add  = owned_reg + {{(ADDR_W-SIZE_W){1'b0}}, need_reg};
        owned_drop = ({{(ADDR_W-SIZE_W){1'b0}}, best_size_reg} > owned_reg) ? '0 :
                     owned_reg - {{(ADDR_W-SIZE_W){1'b0}}, best_size_reg};
        clr_mask   = IDLE_ENTRIES'(1) << best_idx_reg[IDLE_AW-1:0];

        unique case (state_reg)
            ST_IDLE:
            begin
                sidx_next  = '0;
                dv_next    = 1'b0;
                found_next = 1'b0;
                if (s_tvalid)
                begin
                    need_next = round_need;
                    addr_next = s_tdata[88:41];
                    slot_next = live_free_idx;
                    if (!s_tuser)
                    begin
                        res_addr_next = '0;
                        res_last_next = 1'b1;
                        after_next    = ST_IDLE;
                        if (s_tdata[40:0] == '0)
                        begin
                            res_status_next = RES_NULL;
                            res_size_next   = '0;
                            state_next      = ST_EMIT;
                        end
                        else if (live_full)
                        begin
                            res_status_next = RES_FULL;
                            res_size_next   = round_need;
                            state_next      = ST_EMIT;
                        end
                        else
                        begin
                            state_next = ST_ALLOC_SCAN;
                        end
                    end
                    else if (s_tdata[88:41] != '0)
                    begin
                        state_next = ST_FREE_SCAN;
                    end
                end
            end
            ST_ALLOC_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_ALLOC_DECIDE;
                end
            end
            ST_ALLOC_DECIDE:
            begin
                state_next    = ST_EMIT;
                after_next    = ST_IDLE;
                res_last_next = 1'b1;
                if (found_reg)
                begin
                    idle_vld_next   = idle_vld_reg & ~clr_mask;
                    live_vld_next[slot_reg] = 1'b1;
                    live_we         = 1'b1;
                    live_wdata      = '{addr: best_addr_reg, size: best_size_reg};
                    res_status_next = RES_HIT;
                    res_addr_next   = best_addr_reg;
                    res_size_next   = best_size_reg;
                end
                else if (addr_reg == '0)
                begin
                    res_status_next = RES_FAIL;
                    res_addr_next   = '0;
                    res_size_next   = need_reg;
                end
                else
                begin
                    owned_next      = owned_add;
                    live_vld_next[slot_reg] = 1'b1;
                    live_we         = 1'b1;
                    res_status_next = RES_GRANT;
                    res_addr_next   = addr_reg;
                    res_size_next   = need_reg;
                    // releases follow while over budget and something is idle
                    if ((owned_add > max_reg) && (|idle_vld_reg))
                    begin
                        res_last_next = 1'b0;
                        after_next    = ST_TRIM_SCAN;
                    end
                end
            end
            ST_TRIM_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_TRIM_REL;
                end
            end
            ST_TRIM_REL:
            begin
                idle_vld_next   = idle_vld_reg & ~clr_mask;
                owned_next      = owned_drop;
                res_status_next = RES_RELEASED;
                res_addr_next   = best_addr_reg;
                res_size_next   = best_size_reg;
                state_next      = ST_EMIT;
                if ((owned_drop > max_reg) && (|(idle_vld_reg & ~clr_mask)))
                begin
                    res_last_next = 1'b0;
                    after_next    = ST_TRIM_SCAN;
                end
                else
                begin
                    res_last_next = 1'b1;
                    after_next    = ST_IDLE;
                end
            end
            ST_FREE_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_FREE_DECIDE;
                end
            end
            ST_FREE_DECIDE:
            begin
                res_last_next = 1'b1;
                after_next    = ST_IDLE;
                fsize_next    = best_size_reg;
                sidx_next     = '0;
                dv_next       = 1'b0;
                found_next    = 1'b0;
                done_next     = '0;
                ren_k_next    = '0;
                if (!found_reg)
                begin
                    res_status_next = RES_BAD_FREE;
                    res_addr_next   = addr_reg;
                    res_size_next   = '0;
                    state_next      = ST_EMIT;
                end
                else
                begin
                    live_vld_next[best_idx_reg[LIVE_AW-1:0]] = 1'b0;
                    if (idle_full)
                    begin
                        owned_next      = owned_drop;
                        res_status_next = RES_RELEASED;
                        res_addr_next   = addr_reg;
                        res_size_next   = best_size_reg;
                        state_next      = ST_EMIT;
                    end
                    else if (cnt_reg >= STAMP_LIMIT)
                    begin
                        state_next = ST_REN_SCAN;
                    end
                    else
                    begin
                        state_next = ST_FREE_STORE;
                    end
                end
            end
            ST_REN_SCAN:
            begin
                if (scan_done)
                begin
                    state_next = ST_REN_WRITE;
                end
            end
            ST_REN_WRITE:
            begin
                // oldest remaining idle entry takes the next rank
                sidx_next  = '0;
                dv_next    = 1'b0;
                found_next = 1'b0;
                if (found_reg)
                begin
                    idle_we    = 1'b1;
                    idle_waddr = best_idx_reg[IDLE_AW-1:0];
                    idle_wdata = '{size: best_size_reg, addr: best_addr_reg,
                                   stamp: STAMP_W'(ren_k_reg)};
                    done_next  = done_reg | clr_mask;
                    ren_k_next = ren_k_reg + REN_CW'(1);
                    state_next = ST_REN_SCAN;
                end
                else
                begin
                    cnt_next   = STAMP_W'(ren_k_reg);
                    state_next = ST_FREE_STORE;
                end
            end
            ST_FREE_STORE:
            begin
                idle_we                      = 1'b1;
                idle_vld_next[idle_free_idx] = 1'b1;
                cnt_next                     = cnt_reg + STAMP_W'(1);
                state_next                   = ST_IDLE;
            end
            ST_EMIT:
            begin
                sidx_next  = '0;
                dv_next    = 1'b0;
                found_next = 1'b0;
                if (out_free)
                begin
                    ov_next       = 1'b1;
                    o_status_next = res_status_reg;
                    o_addr_next   = res_addr_reg;
                    o_size_next   = res_size_reg;
                    o_last_next   = res_last_reg;
                    state_next    = after_reg;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            after_reg    <= ST_IDLE;
            max_reg      <= BUDGET_RESET;
            owned_reg    <= '0;
            cnt_reg      <= '0;
            idle_vld_reg <= '0;
            live_vld_reg <= '0;
            done_reg     <= '0;
            ren_k_reg    <= '0;
            sidx_reg     <= '0;
            didx_reg     <= '0;
            dv_reg       <= 1'b0;
            found_reg    <= 1'b0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            after_reg    <= after_next;
            max_reg      <= cfg_wr_en ? cfg_wr_data : max_reg;
            owned_reg    <= owned_next;
            cnt_reg      <= cnt_next;
            idle_vld_reg <= idle_vld_next;
            live_vld_reg <= live_vld_next;
            done_reg     <= done_next;
            ren_k_reg    <= ren_k_next;
            sidx_reg     <= sidx_next;
            didx_reg     <= didx_next;
            dv_reg       <= dv_next;
            found_reg    <= found_next;
            ov_reg       <= ov_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        need_reg       <= need_next;
        fsize_reg      <= fsize_next;
        addr_reg       <= addr_next;
        slot_reg       <= slot_next;
        best_idx_reg   <= best_idx_next;
        best_size_reg  <= best_size_next;
        best_addr_reg  <= best_addr_next;
        best_stamp_reg <= best_stamp_next;
        res_status_reg <= res_status_next;
        res_addr_reg   <= res_addr_next;
        res_size_reg   <= res_size_next;
        res_last_reg   <= res_last_next;
        o_status_reg   <= o_status_next;
        o_addr_reg     <= o_addr_next;
        o_size_reg     <= o_size_next;
        o_last_reg     <= o_last_next;
    end

    // result port
    assign m_tvalid = ov_reg;
    assign m_tdata  = {7'd0, o_size_reg, o_addr_reg};
    assign m_tuser  = o_status_reg;
    assign m_tlast  = o_last_reg;

    // checks
    a_trim_has_victim: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_TRIM_REL) |-> found_reg)
        else $error("trim release without an idle block");

    a_stamp_renumbered: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FREE_STORE) |-> (cnt_reg != STAMP_LIMIT))
        else $error("free stamp stored at wrap value");

    a_hit_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser == RES_HIT)) |-> m_tlast)
        else $error("cache hit not marked last");

    a_rank_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ren_k_reg <= REN_CW'(IDLE_ENTRIES))
        else $error("renumber rank out of range");

endmodule : caching_block_allocator_core
`default_nettype wire
